[design/upet_pkg.sv]
// Shared types and constants for the unordered pair exclusion table.
// Depends on nothing; every other design file refers to it by scoped names.

package upet_pkg;

    // Fixed field widths of the item ports.
    localparam int FUNC_W   = 2;
    localparam int IDX_IN_W = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int ENTRY_W  = 17;

    // Operation codes carried in the func field.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_DUMP   = 2'd3
    } t_func;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_CHANGED   = 3'd0,
        ST_UNCHANGED = 3'd1,
        ST_SAME      = 3'd2,
        ST_FULL      = 3'd3,
        ST_ENTRY     = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_LOOK  = 2'd1,
        S_APPLY = 2'd2,
        S_DUMP  = 2'd3
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;        // capture the incoming item
        logic look;        // register the per-entry compare flags
        logic apply;       // update the table and load the result
        logic dump_start;  // load the dump counter
        logic dump_step;   // emit the head entry and rotate
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_dump;     // captured item is a dump
        logic out_free;    // output register can take a result this cycle
        logic dump_last;   // this dump step emits the final result
    } t_stat;

endpackage

[design/upet_if.sv]
// Item channel interfaces for the unordered pair exclusion table.
// Depends on upet_pkg for the payload widths.

// Input channel: one operation per item.
interface upet_in_if;
    logic                              valid;
    logic                              ready;
    logic [upet_pkg::FUNC_W-1:0]       func;
    logic [upet_pkg::IDX_IN_W-1:0]     index_a;
    logic [upet_pkg::IDX_IN_W-1:0]     index_b;

    modport source (output valid, output func, output index_a, output index_b, input ready);
    modport sink   (input valid, input func, input index_a, input index_b, output ready);
endinterface

// Output channel: each item is one result; a dump gives one per stored pair, or one when empty.
interface upet_out_if;
    logic                              valid;
    logic                              ready;
    logic [upet_pkg::STATUS_W-1:0]     status;
    logic                              found;
    logic [upet_pkg::COUNT_W-1:0]      stored_count;
    logic [upet_pkg::ENTRY_W-1:0]      entry_low;
    logic [upet_pkg::ENTRY_W-1:0]      entry_high;
    logic                              last;

    modport source (output valid, output status, output found, output stored_count,
                    output entry_low, output entry_high, output last, input ready);
    modport sink   (input valid, input status, input found, input stored_count,
                    input entry_low, input entry_high, input last, output ready);
endinterface

[design/unordered_pair_exclusion_table_top.sv]
// Add, remove, query: the compare flags are registered, then the cells shift and the
// result loads when the output register is free; the next item can be taken in that
// same cycle. Dump: one result per cycle per stored pair while results are taken (one
// when empty); the next item is taken in the cycle after the last is loaded. Reset
// (i_rst_n low, synchronous) clears the pair count, controller and result valid, not
// the stored pairs. Joins the controller and datapath to the channels.

module unordered_pair_exclusion_table_top #(
    parameter int TABLE_DEPTH = 64,
    parameter int INDEX_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    upet_in_if.sink    i_in,
    upet_out_if.source o_out
);

    upet_pkg::t_cmd  cmd;
    upet_pkg::t_stat stat;
    logic            in_ready;

    // Sequencing of each item.
    upet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // Table storage and result register.
    upet_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .INDEX_BITS  (INDEX_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (i_in.func),
        .i_index_a    (i_in.index_a),
        .i_index_b    (i_in.index_b),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_status     (o_out.status),
        .o_found      (o_out.found),
        .o_count      (o_out.stored_count),
        .o_entry_low  (o_out.entry_low),
        .o_entry_high (o_out.entry_high),
        .o_last       (o_out.last)
    );

    assign i_in.ready = in_ready;

endmodule

[design/upet_ctrl.sv]
// Controller state machine for the unordered pair exclusion table.
// Depends on upet_pkg for the state, command and status types.

module upet_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  upet_pkg::t_stat  i_stat,
    output logic             o_in_ready,
    output upet_pkg::t_cmd   o_cmd
);

    upet_pkg::t_state r_state;
    upet_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= upet_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state. A finished update frees the block for the next item at once.
    always_comb begin
        n_state = r_state;
        case (r_state)
            upet_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = upet_pkg::S_LOOK;
                end
            end
            upet_pkg::S_LOOK: begin
                n_state = i_stat.is_dump ? upet_pkg::S_DUMP : upet_pkg::S_APPLY;
            end
            upet_pkg::S_APPLY: begin
                if (i_stat.out_free) begin
                    n_state = i_in_valid ? upet_pkg::S_LOOK : upet_pkg::S_IDLE;
                end
            end
            upet_pkg::S_DUMP: begin
                if (i_stat.out_free && i_stat.dump_last) begin
                    n_state = upet_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = upet_pkg::S_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            upet_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
            end
            upet_pkg::S_LOOK: begin
                o_cmd.look       = 1'b1;
                o_cmd.dump_start = i_stat.is_dump;
            end
            upet_pkg::S_APPLY: begin
                o_cmd.apply = i_stat.out_free;
                o_in_ready  = i_stat.out_free;
            end
            upet_pkg::S_DUMP: begin
                o_cmd.dump_step = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.take = o_in_ready && i_in_valid;
    end

endmodule

[design/upet_dp.sv]
// Datapath of the unordered pair exclusion table: sorted compare-and-shift
// store, pair count, dump counter and result register. Depends on upet_pkg.

module upet_dp #(
    parameter int TABLE_DEPTH = 64,
    parameter int INDEX_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  upet_pkg::t_cmd                  i_cmd,
    output upet_pkg::t_stat                 o_stat,
    input  logic [upet_pkg::FUNC_W-1:0]     i_func,
    input  logic [upet_pkg::IDX_IN_W-1:0]   i_index_a,
    input  logic [upet_pkg::IDX_IN_W-1:0]   i_index_b,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [upet_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_found,
    output logic [upet_pkg::COUNT_W-1:0]    o_count,
    output logic [upet_pkg::ENTRY_W-1:0]    o_entry_low,
    output logic [upet_pkg::ENTRY_W-1:0]    o_entry_high,
    output logic                            o_last
);

    localparam int KEY_W = 2 * INDEX_BITS;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef logic [KEY_W-1:0] t_key;

    // Captured item.
    upet_pkg::t_func          r_func;
    logic                     r_same;
    logic [INDEX_BITS-1:0]    r_lo;
    logic [INDEX_BITS-1:0]    r_hi;

    // Table state.
    t_key                     r_store [TABLE_DEPTH];
    logic [CNT_W-1:0]         r_total;
    logic [TABLE_DEPTH-1:0]   r_lt;
    logic [TABLE_DEPTH-1:0]   r_eq;
    logic [CNT_W-1:0]         r_dump_left;

    // Result register.
    logic                     r_out_valid;
    upet_pkg::t_status        r_status;
    logic                     r_found;
    logic [upet_pkg::COUNT_W-1:0] r_count;
    logic [upet_pkg::ENTRY_W-1:0] r_entry_low;
    logic [upet_pkg::ENTRY_W-1:0] r_entry_high;
    logic                     r_last;

    logic [INDEX_BITS-1:0]    idx_a;
    logic [INDEX_BITS-1:0]    idx_b;
    t_key                     key;
    wire  [TABLE_DEPTH-1:0]   cmp_lt;
    wire  [TABLE_DEPTH-1:0]   cmp_eq;
    wire  t_key               n_store [TABLE_DEPTH];
    logic                     hit;
    logic                     full;
    logic                     out_free;
    logic                     do_ins;
    logic                     do_del;
    logic                     do_rot;
    logic                     load_out;
    logic [CNT_W-1:0]         n_total;
    upet_pkg::t_status        res_status;
    logic                     res_found;
    logic                     res_last;
    logic [INDEX_BITS:0]      head_lo_p1;
    logic [INDEX_BITS:0]      head_hi_p1;

    // Indices are taken modulo the index width and ordered into (smaller, larger).
    assign idx_a = INDEX_BITS'(i_index_a);
    assign idx_b = INDEX_BITS'(i_index_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_func <= upet_pkg::t_func'(i_func);
            r_same <= (idx_a == idx_b);
            r_lo   <= (idx_a < idx_b) ? idx_a : idx_b;
            r_hi   <= (idx_a < idx_b) ? idx_b : idx_a;
        end
    end

    assign key = {r_lo, r_hi};

    // One cell per entry: compare against the key and pick the next value
    // from itself or a neighbor for insert, delete or dump rotation.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic in_use;
        logic lt_prev;
        t_key up_val;
        t_key dn_val;

        assign in_use     = (CNT_W'(g) < r_total);
        assign cmp_lt[g]  = in_use && (r_store[g] < key);
        assign cmp_eq[g]  = in_use && (r_store[g] == key);

        if (g == 0) begin : g_head
            assign lt_prev = 1'b1;
            assign up_val  = key;
        end else begin : g_body
            assign lt_prev = r_lt[g-1];
            assign up_val  = r_store[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign dn_val = r_store[g];
        end else begin : g_inner
            assign dn_val = r_store[g+1];
        end

        assign n_store[g] =
            (do_ins && !r_lt[g]) ? (lt_prev ? key : up_val) :
            (do_del && !r_lt[g]) ? dn_val :
            (do_rot && in_use)   ? ((CNT_W'(g + 1) == r_total) ? r_store[0] : dn_val) :
                                   r_store[g];
    end

    // Compare flags are registered before the update uses them.
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_lt <= cmp_lt;
            r_eq <= cmp_eq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
    end

    assign hit      = |r_eq;
    assign full     = (r_total == DEPTH_CNT);
    assign out_free = !r_out_valid || i_out_ready;

    // Dump values come from the head cell, shifted to 1-based.
    assign head_lo_p1 = {1'b0, r_store[0][KEY_W-1:INDEX_BITS]} + 1'b1;
    assign head_hi_p1 = {1'b0, r_store[0][INDEX_BITS-1:0]} + 1'b1;

    // Operation decode and result selection.
    always_comb begin
        do_ins     = 1'b0;
        do_del     = 1'b0;
        do_rot     = 1'b0;
        load_out   = 1'b0;
        n_total    = r_total;
        res_status = upet_pkg::ST_UNCHANGED;
        res_found  = 1'b0;
        res_last   = 1'b1;
        if (i_cmd.apply) begin
            load_out = 1'b1;
            if (r_same) begin
                res_status = upet_pkg::ST_SAME;
            end else begin
                case (r_func)
                    upet_pkg::FUNC_ADD: begin
                        if (hit) begin
                            res_status = upet_pkg::ST_UNCHANGED;
                        end else if (full) begin
                            res_status = upet_pkg::ST_FULL;
                        end else begin
                            do_ins     = 1'b1;
                            n_total    = r_total + CNT_W'(1);
                            res_status = upet_pkg::ST_CHANGED;
                        end
                    end
                    upet_pkg::FUNC_REMOVE: begin
                        if (hit) begin
                            do_del     = 1'b1;
                            n_total    = r_total - CNT_W'(1);
                            res_status = upet_pkg::ST_CHANGED;
                        end
                    end
                    upet_pkg::FUNC_QUERY: begin
                        if (hit) begin
                            res_status = upet_pkg::ST_CHANGED;
                            res_found  = 1'b1;
                        end
                    end
                    default: begin
                        res_status = upet_pkg::ST_UNCHANGED;
                    end
                endcase
            end
        end else if (i_cmd.dump_step) begin
            load_out = 1'b1;
            if (r_dump_left != '0) begin
                do_rot     = 1'b1;
                res_status = upet_pkg::ST_ENTRY;
                res_last   = (r_dump_left == CNT_W'(1));
            end
        end
    end

    // Pair count and dump counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_dump_left <= '0;
        end else begin
            r_total <= n_total;
            if (i_cmd.dump_start) begin
                r_dump_left <= r_total;
            end else if (do_rot) begin
                r_dump_left <= r_dump_left - CNT_W'(1);
            end
        end
    end

    // Result register: holds until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_status     <= res_status;
            r_found      <= res_found;
            r_count      <= upet_pkg::COUNT_W'(n_total);
            r_entry_low  <= do_rot ? upet_pkg::ENTRY_W'(head_lo_p1) : '0;
            r_entry_high <= do_rot ? upet_pkg::ENTRY_W'(head_hi_p1) : '0;
            r_last       <= res_last;
        end
    end

    assign o_stat.is_dump   = (r_func == upet_pkg::FUNC_DUMP);
    assign o_stat.out_free  = out_free;
    assign o_stat.dump_last = (r_dump_left <= CNT_W'(1));

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_found      = r_found;
    assign o_count      = r_count;
    assign o_entry_low  = r_entry_low;
    assign o_entry_high = r_entry_high;
    assign o_last       = r_last;

endmodule

[design/upet_checker.sv]
// Port-level checks for the unordered pair exclusion table, bound to the top level.
// Depends on upet_pkg for the status codes.

module upet_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [upet_pkg::STATUS_W-1:0] i_status,
    input logic                          i_found,
    input logic [upet_pkg::ENTRY_W-1:0]  i_entry_low,
    input logic [upet_pkg::ENTRY_W-1:0]  i_entry_high,
    input logic                          i_last
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // An accepted item is worked on before the next one is taken.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an item was taken");

    // Found is only reported with the found status.
    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found |-> i_status == upet_pkg::ST_CHANGED)
        else $error("found set with a wrong status");

    // Only dump entries carry pair values, and every other result ends its item.
    a_plain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != upet_pkg::ST_ENTRY |->
            i_entry_low == '0 && i_entry_high == '0 && i_last)
        else $error("non-entry result with entry values or without last");

    // No new item is taken while a dump entry other than the last is offered.
    a_dump_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == upet_pkg::ST_ENTRY && !i_last |-> !i_in_ready)
        else $error("input ready during a dump");

endmodule

bind unordered_pair_exclusion_table_top upet_checker u_upet_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_found      (o_out.found),
    .i_entry_low  (o_out.entry_low),
    .i_entry_high (o_out.entry_high),
    .i_last       (o_out.last)
);
